### hdl/two_bit_bimodal_predictor_core_macros.svh
// assertion macros used by the predictor back end (tbbp_back)
`ifndef TWO_BIT_BIMODAL_PREDICTOR_CORE_MACROS_SVH
`define TWO_BIT_BIMODAL_PREDICTOR_CORE_MACROS_SVH

// same-cycle implication
`define TBBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbbp assertion failed");

// next-cycle implication
`define TBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbbp assertion failed");

`endif

### hdl/tbbp_pkg.sv
package tbbp_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int ADDR_W      = 64;
    localparam int CFG_W       = 4;
    localparam int COUNT_W     = 32;

    localparam int S_TDATA_W   = ((ADDR_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 + COUNT_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd11;

    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_STRONG_NT = 2'b00;
    localparam t_ctr CTR_WEAK_NT   = 2'b01;
    localparam t_ctr CTR_WEAK_T    = 2'b10;
    localparam t_ctr CTR_STRONG_T  = 2'b11;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             taken;
    } t_req;

endpackage

### hdl/tbbp_front.sv
module tbbp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbbp_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_tvalid,
    output logic                               o_tready,
    input  logic [tbbp_pkg::ADDR_W-1:0]        i_addr,
    input  logic                               i_taken,
    input  logic                               i_back_busy,
    output logic                               o_req_vld,
    input  logic                               i_req_ready,
    output tbbp_pkg::t_req                     o_req
);

    logic [tbbp_pkg::CFG_W-1:0]  r_index_bits;
    tbbp_pkg::t_req              r_q [tbbp_pkg::QUEUE_DEPTH];
    logic [tbbp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [tbbp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [tbbp_pkg::QCNT_W-1:0] r_cnt;
    logic [tbbp_pkg::QCNT_W-1:0] n_cnt;

    logic [tbbp_pkg::IDX_W-1:0]  mask;
    tbbp_pkg::t_req              new_req;
    logic                        push;
    logic                        pop;

    // index mask from the configured width
    always_comb begin
        for (int i = 0; i < tbbp_pkg::IDX_W; i++) begin
            mask[i] = (r_index_bits > tbbp_pkg::CFG_W'(i));
        end
    end

    assign new_req.idx   = i_addr[tbbp_pkg::IDX_W-1:0] & mask;
    assign new_req.taken = i_taken;

    assign o_tready  = (r_cnt != tbbp_pkg::QCNT_W'(tbbp_pkg::QUEUE_DEPTH)) && !i_back_busy;
    assign push      = i_tvalid && o_tready;
    assign o_req_vld = (r_cnt != '0);
    assign pop       = o_req_vld && i_req_ready;
    assign o_req     = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= tbbp_pkg::INDEX_BITS_RESET;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_index_bits <= i_cfg_wdata;
            end
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_req;
        end
    end

endmodule

### hdl/tbbp_back.sv
`include "two_bit_bimodal_predictor_core_macros.svh"

module tbbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_vld,
    output logic                          o_req_ready,
    input  tbbp_pkg::t_req                i_req,
    output logic                          o_busy,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic                          o_pred,
    output logic                          o_correct,
    output logic [tbbp_pkg::COUNT_W-1:0]  o_count
);

    tbbp_pkg::t_ctr              r_mem [tbbp_pkg::TABLE_DEPTH];

    logic                        r_clr_active;
    logic [tbbp_pkg::IDX_W-1:0]  r_clr_addr;

    logic                        r_s1_vld;
    tbbp_pkg::t_req              r_s1;
    tbbp_pkg::t_ctr              r_rdata;

    logic                        r_fwd_vld;
    logic [tbbp_pkg::IDX_W-1:0]  r_fwd_idx;
    tbbp_pkg::t_ctr              r_fwd_ctr;

    logic [tbbp_pkg::COUNT_W-1:0] r_count;
    logic [tbbp_pkg::COUNT_W-1:0] n_count;

    logic                        r_out_vld;
    logic                        r_out_pred;
    logic                        r_out_corr;
    logic [tbbp_pkg::COUNT_W-1:0] r_out_cnt;

    logic                        s1_fire;
    logic                        pop;
    tbbp_pkg::t_ctr              ctr_cur;
    tbbp_pkg::t_ctr              ctr_nxt;
    logic                        pred;
    logic                        correct;

    logic                        mem_we;
    logic [tbbp_pkg::IDX_W-1:0]  mem_waddr;
    tbbp_pkg::t_ctr              mem_wdata;

    assign s1_fire     = r_s1_vld && (!r_out_vld || i_tready);
    assign o_req_ready = !r_clr_active && (!r_s1_vld || s1_fire);
    assign pop         = i_req_vld && o_req_ready;
    assign o_busy      = r_clr_active;

    // bypass the entry written on the edge that registered the read
    assign ctr_cur = (r_fwd_vld && (r_fwd_idx == r_s1.idx)) ? r_fwd_ctr : r_rdata;
    assign pred    = ctr_cur[1];
    assign correct = (pred == r_s1.taken);

    always_comb begin
        ctr_nxt = ctr_cur;
        if (r_s1.taken) begin
            if (ctr_cur != tbbp_pkg::CTR_STRONG_T) begin
                ctr_nxt = ctr_cur + 1'b1;
            end
        end else begin
            if (ctr_cur != tbbp_pkg::CTR_STRONG_NT) begin
                ctr_nxt = ctr_cur - 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (correct && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = tbbp_pkg::CTR_STRONG_T;
        end else begin
            mem_we    = s1_fire;
            mem_waddr = r_s1.idx;
            mem_wdata = ctr_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            r_rdata <= r_mem[i_req.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_vld     <= 1'b0;
            r_fwd_vld    <= 1'b0;
            r_count      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == tbbp_pkg::IDX_W'(tbbp_pkg::TABLE_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (pop) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_fwd_vld <= 1'b1;
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1 <= i_req;
        end
        if (s1_fire) begin
            r_fwd_idx  <= r_s1.idx;
            r_fwd_ctr  <= ctr_nxt;
            r_out_pred <= pred;
            r_out_corr <= correct;
            r_out_cnt  <= n_count;
        end
    end

    assign o_tvalid  = r_out_vld;
    assign o_pred    = r_out_pred;
    assign o_correct = r_out_corr;
    assign o_count   = r_out_cnt;

    `TBBP_ASSERT_NOW(a_clr_idle, i_clk, i_rst_n, r_clr_active, !r_s1_vld && !r_out_vld)
    `TBBP_ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, s1_fire && correct && (r_count != '1), r_count == $past(r_count) + 1'b1)
    `TBBP_ASSERT_NEXT(a_fwd_track, i_clk, i_rst_n, s1_fire, r_fwd_vld && (r_fwd_idx == $past(r_s1.idx)))

endmodule

### hdl/two_bit_bimodal_predictor_core.sv
// two-bit bimodal branch predictor
// s_axis carries one resolved branch per transaction: the branch address and
// its actual outcome. m_axis returns one result per branch, in order: the
// prediction read before the update, whether it was correct, and the
// saturating count of correct predictions including this branch.
// i_cfg_we/i_cfg_wdata write the index width (number of address bits used);
// write it only while no branch is in flight.
// a branch goes through the queue, the table read and the output register.
// throughput: one branch per cycle absent an m_axis stall, set by one counter
// table read and one table write a cycle, the just-written entry bypassed.
// reset: all counters go to strongly taken by a clearing pass over 2048
// entries, one a cycle, during which s_axis_tready stays low; the count
// restarts at zero and the index width returns to 11.
// a two-entry queue sits between the address decode and the table, and the
// result sits in an output register, so a stall on m_axis_tready holds the
// result while up to three further branches are still taken in.
module two_bit_bimodal_predictor_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tbbp_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // branch_address, outcome_taken, zero pad
    input  logic [tbbp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // predicted_taken, was_correct, correct_count, zero pad
    output logic [tbbp_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    tbbp_pkg::t_req                 req;
    logic                           req_vld;
    logic                           req_ready;
    logic                           back_busy;
    logic                           out_pred;
    logic                           out_corr;
    logic [tbbp_pkg::COUNT_W-1:0]   out_cnt;

    tbbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_addr      (s_axis_tdata[tbbp_pkg::ADDR_W-1:0]),
        .i_taken     (s_axis_tdata[tbbp_pkg::ADDR_W]),
        .i_back_busy (back_busy),
        .o_req_vld   (req_vld),
        .i_req_ready (req_ready),
        .o_req       (req)
    );

    tbbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_vld   (req_vld),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_busy      (back_busy),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_pred      (out_pred),
        .o_correct   (out_corr),
        .o_count     (out_cnt)
    );

    assign m_axis_tdata = {{(tbbp_pkg::M_TDATA_W - 2 - tbbp_pkg::COUNT_W){1'b0}},
                           out_cnt, out_corr, out_pred};

endmodule
